@@ rtl/sgpt_pkg.sv @@
// shared constants, codes and types for the sorted grid point table
package sgpt_pkg;

	localparam int DEPTH   = 32;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int OCC_W   = 6;
	localparam int ENTRY_W = 24;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_ENTRY     = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_WALK = 1'b1
	} state_t;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] label;
	} point_t;

endpackage

@@ rtl/sgpt_ram.sv @@
// generic single write, single registered read memory
module sgpt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/sorted_grid_point_table.sv @@
// sorted grid point table: top level with walk sequencer and point memory
//
// Holds up to DEPTH labelled grid points in ascending row then column order,
// each position at most once. A transaction is taken when start is high and
// busy is low. Insert and remove walk the held entries one per cycle through
// the memory read port and a single key comparator, moving entries up or down
// a place as they pass, and busy stays high until the walk ends, which can be
// early at a duplicate, a full table or a missing position. A dump streams
// one entry per cycle. Every result sits on the result ports for one cycle
// under strobe and the receiver cannot stall it; an insert or remove gives
// one result, a dump gives one per entry (or one empty result), last marks
// the final one, and operation 3 is dropped without results or busy time.
module sorted_grid_point_table
	import sgpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic [7:0]          row,
	input  logic [7:0]          col,
	input  logic [7:0]          label,
	output logic                strobe,
	output logic [2:0]          status,
	output logic [7:0]          entry_row,
	output logic [7:0]          entry_col,
	output logic [7:0]          entry_label,
	output logic [OCC_W-1:0]    occupancy,
	output logic                last
);

	state_t            state_q, state_d;
	op_t               op_q;
	point_t            req_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  aidx_s1;
	logic              found_q, found_d;
	point_t            carry_q, carry_d;

	logic              accept;
	logic              issue;
	logic              finish;
	logic              walk_end;
	logic              full;
	logic              key_eq, key_gt;
	logic [15:0]       key_new, key_rd;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	point_t            wdata;
	logic [ENTRY_W-1:0] rdata;
	point_t            rd_pt;

	logic              res_v;
	status_t           res_status;
	logic [7:0]        res_row, res_col, res_label;
	logic              res_last;

	logic              strobe_q;
	status_t           status_q;
	logic [7:0]        row_q, col_q, label_q;
	logic [OCC_W-1:0]  occ_q;
	logic              last_q;

	sgpt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign rd_pt    = point_t'(rdata);
	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign key_new  = {req_q.row, req_q.col};
	assign key_rd   = {rd_pt.row, rd_pt.col};
	assign key_eq   = (key_rd == key_new);
	assign key_gt   = (key_rd > key_new);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign walk_end = (idx_q == count_q) && !vld_s1;
	assign issue    = (state_q == S_WALK) && (idx_q < count_q) && !finish;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (op_t'(operation) != OP_NONE)) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// walk actions
	always_comb begin
		finish     = 1'b0;
		we         = 1'b0;
		waddr      = aidx_s1;
		wdata      = rd_pt;
		count_d    = count_q;
		found_d    = found_q;
		carry_d    = carry_q;
		res_v      = 1'b0;
		res_status = ST_ENTRY;
		res_row    = req_q.row;
		res_col    = req_q.col;
		res_label  = 8'd0;
		res_last   = 1'b1;
		if (state_q == S_WALK) begin
			case (op_q)
				OP_INSERT: begin
					if (vld_s1) begin
						if (!found_q) begin
							if (key_eq) begin
								finish     = 1'b1;
								res_v      = 1'b1;
								res_status = ST_DUPLICATE;
							end else if (key_gt) begin
								if (full) begin
									finish     = 1'b1;
									res_v      = 1'b1;
									res_status = ST_FULL;
								end else begin
									we      = 1'b1;
									wdata   = req_q;
									carry_d = rd_pt;
									found_d = 1'b1;
								end
							end
						end else begin
							we      = 1'b1;
							wdata   = carry_q;
							carry_d = rd_pt;
						end
					end else if (walk_end) begin
						finish = 1'b1;
						res_v  = 1'b1;
						if (full) begin
							res_status = ST_FULL;
						end else begin
							we         = 1'b1;
							waddr      = count_q[IDX_W-1:0];
							wdata      = found_q ? carry_q : req_q;
							count_d    = count_q + CNT_W'(1);
							res_status = ST_INSERTED;
						end
					end
				end
				OP_REMOVE: begin
					if (vld_s1) begin
						if (!found_q) begin
							if (key_eq) begin
								found_d = 1'b1;
							end else if (key_gt) begin
								finish     = 1'b1;
								res_v      = 1'b1;
								res_status = ST_NOTFOUND;
							end
						end else begin
							we    = 1'b1;
							waddr = aidx_s1 - IDX_W'(1);
						end
					end else if (walk_end) begin
						finish = 1'b1;
						res_v  = 1'b1;
						if (found_q) begin
							count_d    = count_q - CNT_W'(1);
							res_status = ST_REMOVED;
						end else begin
							res_status = ST_NOTFOUND;
						end
					end
				end
				OP_DUMP: begin
					if (vld_s1) begin
						res_v     = 1'b1;
						res_row   = rd_pt.row;
						res_col   = rd_pt.col;
						res_label = rd_pt.label;
						res_last  = ((CNT_W'(aidx_s1) + CNT_W'(1)) == count_q);
					end else if (walk_end) begin
						finish = 1'b1;
						if (count_q == '0) begin
							res_v      = 1'b1;
							res_status = ST_EMPTY;
						end
					end
				end
				default: finish = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			vld_s1   <= issue;
			strobe_q <= res_v;
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				found_q <= found_d;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(operation);
			req_q <= '{row: row, col: col, label: label};
		end
		aidx_s1 <= idx_q[IDX_W-1:0];
		carry_q <= carry_d;
		if (res_v) begin
			status_q <= res_status;
			row_q    <= res_row;
			col_q    <= res_col;
			label_q  <= res_label;
			occ_q    <= OCC_W'(count_d);
			last_q   <= res_last;
		end
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign entry_row   = row_q;
	assign entry_col   = col_q;
	assign entry_label = label_q;
	assign occupancy   = occ_q;
	assign last        = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("point count above depth");

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a transaction in progress");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_WALK))
		else $error("memory write outside a walk");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status_q == ST_INSERTED)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the table");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status_q != ST_ENTRY)) |-> last)
		else $error("single result without last");

endmodule

@@ verif/tb_sorted_grid_point_table.sv @@
// testbench for the sorted grid point table: directed and random insert, remove and dump checks
module tb_sorted_grid_point_table
	import sgpt_pkg::*;
;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = DEPTH + 8;

	typedef struct {
		status_t          status;
		logic [7:0]       row;
		logic [7:0]       col;
		logic [7:0]       label;
		logic [OCC_W-1:0] occ;
		logic             last;
	} table_reply_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       operation;
	logic [7:0]       row;
	logic [7:0]       col;
	logic [7:0]       label;
	logic             strobe;
	logic [2:0]       status;
	logic [7:0]       entry_row;
	logic [7:0]       entry_col;
	logic [7:0]       entry_label;
	logic [OCC_W-1:0] occupancy;
	logic             last;

	point_t       held_points [DEPTH];
	int           held_count;
	int           peak_held;
	table_reply_t replies_due [$];
	int           status_hits [7];
	int           mismatches;
	int           replies_checked;
	int           transactions;
	int           cycle_count;
	int           idle_pct;

	sorted_grid_point_table i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still due", cycle_count,
				replies_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	// lower bound of a position in the held table
	function automatic int find_slot(input logic [7:0] r, input logic [7:0] c);
		int i;
		i = 0;
		while (i < held_count && {held_points[i].row, held_points[i].col} < {r, c})
			i++;
		return i;
	endfunction

	function automatic bit position_held(input logic [7:0] r, input logic [7:0] c);
		int i;
		i = find_slot(r, c);
		return i < held_count && {held_points[i].row, held_points[i].col} == {r, c};
	endfunction

	function automatic void queue_reply(input status_t st, input logic [7:0] r,
		input logic [7:0] c, input logic [7:0] lab, input logic lst);
		table_reply_t rep;
		rep.status = st;
		rep.row    = r;
		rep.col    = c;
		rep.label  = lab;
		rep.occ    = OCC_W'(held_count);
		rep.last   = lst;
		replies_due.push_back(rep);
		status_hits[int'(st)]++;
	endfunction

	// applies one transaction to the table copy and queues the replies it causes
	function automatic void update_point_table(input op_t op, input logic [7:0] r,
		input logic [7:0] c, input logic [7:0] lab);
		int  i;
		int  j;
		bit  found;
		i     = find_slot(r, c);
		found = i < held_count && {held_points[i].row, held_points[i].col} == {r, c};
		case (op)
			OP_INSERT: begin
				if (found) begin
					queue_reply(ST_DUPLICATE, r, c, 8'd0, 1'b1);
				end else if (held_count >= DEPTH) begin
					queue_reply(ST_FULL, r, c, 8'd0, 1'b1);
				end else begin
					for (j = held_count; j > i; j--)
						held_points[j] = held_points[j-1];
					held_points[i] = '{row: r, col: c, label: lab};
					held_count++;
					if (held_count > peak_held)
						peak_held = held_count;
					queue_reply(ST_INSERTED, r, c, 8'd0, 1'b1);
				end
			end
			OP_REMOVE: begin
				if (found) begin
					for (j = i; j + 1 < held_count; j++)
						held_points[j] = held_points[j+1];
					held_count--;
					queue_reply(ST_REMOVED, r, c, 8'd0, 1'b1);
				end else begin
					queue_reply(ST_NOTFOUND, r, c, 8'd0, 1'b1);
				end
			end
			OP_DUMP: begin
				if (held_count == 0) begin
					queue_reply(ST_EMPTY, r, c, 8'd0, 1'b1);
				end else begin
					for (j = 0; j < held_count; j++)
						queue_reply(ST_ENTRY, held_points[j].row, held_points[j].col,
							held_points[j].label, j == held_count - 1);
				end
			end
			default: begin
			end
		endcase
	endfunction

	// start is left high so that a following transaction goes out back to back
	task automatic issue_table_op(input op_t op, input logic [7:0] r, input logic [7:0] c,
		input logic [7:0] lab);
		start     <= 1'b1;
		operation <= op;
		row       <= r;
		col       <= c;
		label     <= lab;
		do
			@(posedge clk);
		while (busy);
		update_point_table(op, r, c, lab);
		transactions++;
	endtask

	task automatic sender_gap(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if ($urandom_range(0, 99) < idle_pct)
			sender_gap($urandom_range(1, 40));
	endtask

	task automatic wait_replies_drained();
		start <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// half the positions share a few rows so that column order gets exercised
	task automatic pick_position(output logic [7:0] r, output logic [7:0] c);
		if ($urandom_range(0, 1))
			r = 8'($urandom_range(0, 3));
		else
			r = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
	endtask

	task automatic pick_free_position(output logic [7:0] r, output logic [7:0] c);
		do
			pick_position(r, c);
		while (position_held(r, c));
	endtask

	task automatic pick_held_position(output logic [7:0] r, output logic [7:0] c);
		int idx;
		idx = $urandom_range(0, held_count - 1);
		r   = held_points[idx].row;
		c   = held_points[idx].col;
	endtask

	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n && strobe) begin
			replies_checked++;
			if (replies_due.size() == 0) begin
				report_mismatch("reply with nothing due, status", int'(status), -1);
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (entry_row !== want.row)
					report_mismatch("entry_row", int'(entry_row), int'(want.row));
				if (entry_col !== want.col)
					report_mismatch("entry_col", int'(entry_col), int'(want.col));
				if (entry_label !== want.label)
					report_mismatch("entry_label", int'(entry_label), int'(want.label));
				if (occupancy !== want.occ)
					report_mismatch("occupancy", int'(occupancy), int'(want.occ));
				if (last !== want.last)
					report_mismatch("last", int'(last), int'(want.last));
			end
		end
	end

	task automatic test_directed();
		issue_table_op(OP_DUMP, 8'hFF, 8'h00, 8'hFF);
		issue_table_op(OP_REMOVE, 8'd10, 8'd20, 8'd0);
		issue_table_op(OP_NONE, 8'hAA, 8'h55, 8'hFF);
		issue_table_op(OP_INSERT, 8'd0, 8'd0, 8'h00);
		issue_table_op(OP_INSERT, 8'd255, 8'd255, 8'hFF);
		issue_table_op(OP_INSERT, 8'd0, 8'd255, 8'h5A);
		issue_table_op(OP_INSERT, 8'd255, 8'd0, 8'hA5);
		issue_table_op(OP_INSERT, 8'd128, 8'd7, 8'h3C);
		issue_table_op(OP_INSERT, 8'd128, 8'd6, 8'h01);
		issue_table_op(OP_INSERT, 8'd128, 8'd7, 8'h99);
		issue_table_op(OP_DUMP, 8'd33, 8'd44, 8'd0);
		issue_table_op(OP_REMOVE, 8'd128, 8'd7, 8'hFF);
		issue_table_op(OP_REMOVE, 8'd128, 8'd7, 8'd0);
		issue_table_op(OP_REMOVE, 8'd0, 8'd0, 8'd0);
		issue_table_op(OP_REMOVE, 8'd255, 8'd255, 8'd0);
		issue_table_op(OP_NONE, 8'h55, 8'hAA, 8'h00);
		issue_table_op(OP_DUMP, 8'd0, 8'd0, 8'd0);
		issue_table_op(OP_REMOVE, 8'd0, 8'd255, 8'd0);
		issue_table_op(OP_REMOVE, 8'd255, 8'd0, 8'd0);
		issue_table_op(OP_REMOVE, 8'd128, 8'd6, 8'd0);
		issue_table_op(OP_DUMP, 8'h00, 8'hFF, 8'h00);
		// hold off until the table has answered everything
		wait_replies_drained();
	endtask

	task automatic test_full_table();
		logic [7:0] r;
		logic [7:0] c;
		int         k;
		while (held_count < DEPTH) begin
			if (held_count > 0 && $urandom_range(0, 99) < 10)
				pick_held_position(r, c);
			else
				pick_position(r, c);
			issue_table_op(OP_INSERT, r, c, 8'($urandom_range(0, 255)));
			maybe_idle();
		end
		pick_free_position(r, c);
		issue_table_op(OP_INSERT, r, c, 8'($urandom_range(0, 255)));
		pick_held_position(r, c);
		issue_table_op(OP_INSERT, r, c, 8'($urandom_range(0, 255)));
		issue_table_op(OP_DUMP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0);
		pick_held_position(r, c);
		issue_table_op(OP_REMOVE, r, c, 8'd0);
		pick_free_position(r, c);
		issue_table_op(OP_INSERT, r, c, 8'($urandom_range(0, 255)));
		maybe_idle();
		for (k = 0; k < DEPTH / 2; k++) begin
			pick_held_position(r, c);
			issue_table_op(OP_REMOVE, r, c, 8'($urandom_range(0, 255)));
			maybe_idle();
		end
	endtask

	task automatic test_random_mix(input int n_items);
		logic [7:0] r;
		logic [7:0] c;
		int         k;
		int         pick;
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45 || (held_count == 0 && pick < 70)) begin
				if (held_count > 0 && $urandom_range(0, 99) < 15)
					pick_held_position(r, c);
				else
					pick_position(r, c);
				issue_table_op(OP_INSERT, r, c, 8'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				if (held_count > 0 && $urandom_range(0, 99) < 70)
					pick_held_position(r, c);
				else
					pick_position(r, c);
				issue_table_op(OP_REMOVE, r, c, 8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				issue_table_op(OP_DUMP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end else begin
				issue_table_op(OP_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end
			maybe_idle();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_INSERT;
		row       <= 8'd0;
		col       <= 8'd0;
		label     <= 8'd0;
		held_count      = 0;
		peak_held       = 0;
		mismatches      = 0;
		replies_checked = 0;
		transactions    = 0;
		cycle_count     = 0;
		idle_pct        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		idle_pct = 14;
		test_full_table();
		test_random_mix(12);
		idle_pct = 51;
		test_random_mix(12);
		idle_pct = 0;
		test_random_mix(12);

		wait_replies_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			report_mismatch("replies still due", replies_due.size(), 0);
		$display("%0d transactions, %0d replies checked, peak occupancy %0d of %0d",
			transactions, replies_checked, peak_held, DEPTH);
		$display("duplicates %0d, full %0d, not found %0d, empty dumps %0d, dumped entries %0d",
			status_hits[int'(ST_DUPLICATE)], status_hits[int'(ST_FULL)],
			status_hits[int'(ST_NOTFOUND)], status_hits[int'(ST_EMPTY)],
			status_hits[int'(ST_ENTRY)]);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/sgpt_pkg.sv
rtl/sgpt_ram.sv
rtl/sorted_grid_point_table.sv
verif/tb_sorted_grid_point_table.sv
